### hdl/uscd_pkg.sv
// Shared constants, types and tables for the Unix-seconds-to-calendar-date pipeline.
package uscd_pkg;

	// Port widths.
	localparam int SecsW = 32;
	localparam int DaysW = 16;
	localparam int SodW  = 17;
	localparam int YearW = 12;
	localparam int MonW  = 4;
	localparam int DomW  = 5;
	localparam int HourW = 5;
	localparam int MinW  = 6;
	localparam int SecW  = 6;

	// Time-of-day split. Each divisor is taken apart into a power of two and an odd part.
	localparam int unsigned SecsPerDay  = 86400;
	localparam int unsigned DayShift    = 7;
	localparam int unsigned DayDiv      = SecsPerDay >> DayShift;   // 675
	localparam int unsigned SecsPerHour = 3600;
	localparam int unsigned HourDiv     = SecsPerHour >> 4;         // 225
	localparam int unsigned SecsPerMin  = 60;
	localparam int unsigned MinDiv      = SecsPerMin >> 2;          // 15

	// Calendar constants.
	localparam int unsigned EpochJdn   = 2440588;
	localparam int unsigned JdnOffset  = 32044;
	localparam int unsigned EpochA     = EpochJdn + JdnOffset;
	localparam int unsigned Days400y   = 146097;
	localparam int unsigned Days4y     = 1461;
	localparam int unsigned YearOffset = 4800;
	localparam int unsigned Century    = 100;
	localparam int unsigned MdMul      = 5;
	localparam int unsigned MdAdd      = 2;
	localparam int unsigned MdDiv      = 153;
	localparam int unsigned WrapMonth  = 10;

	// Reciprocals for quotient estimates; each estimate is exact or one low.
	localparam logic [22:0] Recip675    = 23'((64'd1 << 32) / DayDiv);
	localparam logic [8:0]  Recip225    = 9'((64'd1 << 16) / HourDiv);
	localparam logic [12:0] Recip15     = 13'((64'd1 << 16) / MinDiv);
	localparam logic [14:0] Recip146097 = 15'((64'd1 << 32) / Days400y);
	localparam logic [21:0] Recip1461   = 22'((64'd1 << 32) / Days4y);
	localparam logic [8:0]  Recip153    = 9'((64'd1 << 16) / MdDiv);

	typedef struct packed {
		logic [HourW-1:0] hour;
		logic [MinW-1:0]  minute;
		logic [SecW-1:0]  second;
	} tod_t;

	// Day of the March-based year on which month index m starts: (153 * m + 2) / 5.
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] s;
		case (m)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd61;
			4'd3:    s = 9'd92;
			4'd4:    s = 9'd122;
			4'd5:    s = 9'd153;
			4'd6:    s = 9'd184;
			4'd7:    s = 9'd214;
			4'd8:    s = 9'd245;
			4'd9:    s = 9'd275;
			4'd10:   s = 9'd306;
			4'd11:   s = 9'd337;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

endpackage

### hdl/uscd_split.sv
// Splits Unix seconds into a whole day count and the seconds of the day.
module uscd_split (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [uscd_pkg::SecsW-1:0]  unix_seconds,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [uscd_pkg::DaysW-1:0]  days,
	output logic [uscd_pkg::SodW-1:0]   sod
);
	import uscd_pkg::*;

	localparam int Stages = 3;

	logic [Stages:1]   vld_q;
	logic [Stages:1]   en;
	logic [Stages-1:0] vin;

	logic [24:0] x_s1;
	logic [6:0]  lo_s1;
	logic [15:0] qe_s1;
	logic [10:0] r0_s2;
	logic [6:0]  lo_s2;
	logic [15:0] qe_s2;
	logic [15:0] days_s3;
	logic [16:0] sod_s3;

	logic [47:0] p1;
	logic [25:0] d2;
	logic        c3;
	logic [10:0] r3;

	// A stage takes new data when it is empty or its successor moves on.
	generate
		for (genvar k = 1; k < Stages; k++) begin : g_en
			assign en[k] = !vld_q[k] || en[k+1];
		end
	endgenerate
	assign en[Stages] = !vld_q[Stages] || out_ready;
	assign vin        = {vld_q[Stages-1:1], in_valid};
	assign in_ready   = en[1];
	assign out_valid  = vld_q[Stages];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= Stages; k++) begin
				if (en[k]) begin
					vld_q[k] <= vin[k-1];
				end
			end
		end
	end

	assign p1 = 48'(unix_seconds[31:7]) * 48'(Recip675);
	assign d2 = 26'(x_s1) - 26'(qe_s1) * 26'(DayDiv);
	assign c3 = r0_s2 >= 11'(DayDiv);
	assign r3 = c3 ? r0_s2 - 11'(DayDiv) : r0_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			x_s1  <= unix_seconds[31:7];
			lo_s1 <= unix_seconds[6:0];
			qe_s1 <= p1[47:32];
		end
		if (en[2]) begin
			r0_s2 <= d2[10:0];
			lo_s2 <= lo_s1;
			qe_s2 <= qe_s1;
		end
		if (en[3]) begin
			days_s3 <= qe_s2 + 16'(c3);
			sod_s3  <= {r3[9:0], lo_s2};
		end
	end

	assign days = days_s3;
	assign sod  = sod_s3;

endmodule

### hdl/uscd_time.sv
// Turns the seconds of the day into hour, minute and second; carries the day count along.
module uscd_time (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [uscd_pkg::DaysW-1:0]  days,
	input  logic [uscd_pkg::SodW-1:0]   sod,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [uscd_pkg::DaysW-1:0]  epoch_days,
	output uscd_pkg::tod_t              tod
);
	import uscd_pkg::*;

	localparam int Stages = 6;

	logic [Stages:1]   vld_q;
	logic [Stages:1]   en;
	logic [Stages-1:0] vin;

	logic [DaysW-1:0] dc_s [1:Stages];

	logic [12:0] y_s1;
	logic [3:0]  lo4_s1;
	logic [4:0]  he_s1;
	logic [8:0]  r0_s2;
	logic [3:0]  lo4_s2;
	logic [4:0]  he_s2;
	logic [4:0]  hh_s3;
	logic [11:0] rem_s3;
	logic [4:0]  hh_s4;
	logic [9:0]  z_s4;
	logic [1:0]  lo2_s4;
	logic [5:0]  me_s4;
	logic [4:0]  hh_s5;
	logic [5:0]  me_s5;
	logic [1:0]  lo2_s5;
	logic [4:0]  r0_s5;
	tod_t        tod_s6;

	logic [21:0] p1;
	logic [13:0] d2;
	logic        c3;
	logic [8:0]  r3;
	logic [22:0] p4;
	logic [10:0] d5;
	logic        c6;
	logic [4:0]  r6;

	generate
		for (genvar k = 1; k < Stages; k++) begin : g_en
			assign en[k] = !vld_q[k] || en[k+1];
		end
	endgenerate
	assign en[Stages] = !vld_q[Stages] || out_ready;
	assign vin        = {vld_q[Stages-1:1], in_valid};
	assign in_ready   = en[1];
	assign out_valid  = vld_q[Stages];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= Stages; k++) begin
				if (en[k]) begin
					vld_q[k] <= vin[k-1];
				end
			end
		end
	end

	// Hours: sod / 3600 is (sod >> 4) / 225 with the low four bits kept aside.
	assign p1 = 22'(sod[16:4]) * 22'(Recip225);
	assign d2 = 14'(y_s1) - 14'(he_s1) * 14'(HourDiv);
	assign c3 = r0_s2 >= 9'(HourDiv);
	assign r3 = c3 ? r0_s2 - 9'(HourDiv) : r0_s2;

	// Minutes: rem / 60 is (rem >> 2) / 15 with the low two bits kept aside.
	assign p4 = 23'(rem_s3[11:2]) * 23'(Recip15);
	assign d5 = 11'(z_s4) - 11'(me_s4) * 11'(MinDiv);
	assign c6 = r0_s5 >= 5'(MinDiv);
	assign r6 = c6 ? r0_s5 - 5'(MinDiv) : r0_s5;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			dc_s[1] <= days;
			y_s1    <= sod[16:4];
			lo4_s1  <= sod[3:0];
			he_s1   <= p1[20:16];
		end
		for (int k = 2; k <= Stages; k++) begin
			if (en[k]) begin
				dc_s[k] <= dc_s[k-1];
			end
		end
		if (en[2]) begin
			r0_s2  <= d2[8:0];
			lo4_s2 <= lo4_s1;
			he_s2  <= he_s1;
		end
		if (en[3]) begin
			hh_s3  <= he_s2 + 5'(c3);
			rem_s3 <= {r3[7:0], lo4_s2};
		end
		if (en[4]) begin
			hh_s4  <= hh_s3;
			z_s4   <= rem_s3[11:2];
			lo2_s4 <= rem_s3[1:0];
			me_s4  <= p4[21:16];
		end
		if (en[5]) begin
			hh_s5  <= hh_s4;
			me_s5  <= me_s4;
			lo2_s5 <= lo2_s4;
			r0_s5  <= d5[4:0];
		end
		if (en[6]) begin
			tod_s6.hour   <= hh_s5;
			tod_s6.minute <= me_s5 + 6'(c6);
			tod_s6.second <= {r6[3:0], lo2_s5};
		end
	end

	assign epoch_days = dc_s[Stages];
	assign tod        = tod_s6;

endmodule

### hdl/uscd_date.sv
// Converts a day count since the epoch into a Gregorian year, month and day.
module uscd_date (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [uscd_pkg::DaysW-1:0]  epoch_days,
	input  uscd_pkg::tod_t              tod,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [uscd_pkg::YearW-1:0]  year,
	output logic [uscd_pkg::MonW-1:0]   month,
	output logic [uscd_pkg::DomW-1:0]   day_of_month,
	output uscd_pkg::tod_t              clock_time
);
	import uscd_pkg::*;

	localparam int Stages = 14;

	logic [Stages:1]   vld_q;
	logic [Stages:1]   en;
	logic [Stages-1:0] vin;

	tod_t tod_s [1:Stages];

	logic [21:0] a_s1, a_s2, a_s3, a_s4;
	logic [6:0]  be_s2, be_s3;
	logic [18:0] r0_s3;
	logic [6:0]  b_s4, b_s5, b_s6, b_s7, b_s8;
	logic [15:0] c_s5, c_s6, c_s7, c_s8;
	logic [6:0]  de_s6, de_s7;
	logic [11:0] rd_s7;
	logic [6:0]  d_s8;
	logic [8:0]  e_s9, e_s10, e_s11, e_s12, e_s13;
	logic [11:0] yb_s9, yb_s10, yb_s11, yb_s12, yb_s13;
	logic [10:0] nm_s10, nm_s11;
	logic [3:0]  me_s11, me_s12;
	logic [8:0]  rm_s12;
	logic [3:0]  m_s13;
	logic [YearW-1:0] year_s14;
	logic [MonW-1:0]  month_s14;
	logic [DomW-1:0]  dom_s14;

	logic [38:0] p2;
	logic [23:0] d3;
	logic [23:0] f5;
	logic [21:0] c5;
	logic [39:0] p6;
	logic [17:0] d7;
	logic [17:0] f9;
	logic [15:0] e9;
	logic [13:0] y9;
	logic [19:0] p11;
	logic [10:0] d12;
	logic        wrap14;
	logic [8:0]  t14;

	generate
		for (genvar k = 1; k < Stages; k++) begin : g_en
			assign en[k] = !vld_q[k] || en[k+1];
		end
	endgenerate
	assign en[Stages] = !vld_q[Stages] || out_ready;
	assign vin        = {vld_q[Stages-1:1], in_valid};
	assign in_ready   = en[1];
	assign out_valid  = vld_q[Stages];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= Stages; k++) begin
				if (en[k]) begin
					vld_q[k] <= vin[k-1];
				end
			end
		end
	end

	// Four-century cycle: b = (4a + 3) / 146097, then c = a - 146097 * b / 4.
	assign p2 = 39'({a_s1, 2'b11}) * 39'(Recip146097);
	assign d3 = {a_s2, 2'b11} - 24'(be_s2) * 24'(Days400y);
	assign f5 = 24'(b_s4) * 24'(Days400y);
	assign c5 = a_s4 - f5[23:2];

	// Four-year cycle: d = (4c + 3) / 1461, then e = c - 1461 * d / 4.
	assign p6 = 40'({c_s5, 2'b11}) * 40'(Recip1461);
	assign d7 = {c_s6, 2'b11} - 18'(de_s6) * 18'(Days4y);
	assign f9 = 18'(d_s8) * 18'(Days4y);
	assign e9 = c_s8 - f9[17:2];
	assign y9 = 14'(b_s8) * 14'(Century) + 14'(d_s8) - 14'(YearOffset);

	// Month within the March-based year: m = (5e + 2) / 153.
	assign p11 = 20'(nm_s10) * 20'(Recip153);
	assign d12 = nm_s11 - 11'(me_s11) * 11'(MdDiv);

	assign wrap14 = m_s13 >= 4'(WrapMonth);
	assign t14    = e_s13 - month_start(m_s13) + 9'd1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			tod_s[1] <= tod;
			a_s1     <= 22'(epoch_days) + 22'(EpochA);
		end
		for (int k = 2; k <= Stages; k++) begin
			if (en[k]) begin
				tod_s[k] <= tod_s[k-1];
			end
		end
		if (en[2]) begin
			a_s2  <= a_s1;
			be_s2 <= p2[38:32];
		end
		if (en[3]) begin
			a_s3  <= a_s2;
			be_s3 <= be_s2;
			r0_s3 <= d3[18:0];
		end
		if (en[4]) begin
			a_s4 <= a_s3;
			b_s4 <= be_s3 + 7'(r0_s3 >= 19'(Days400y));
		end
		if (en[5]) begin
			b_s5 <= b_s4;
			c_s5 <= c5[15:0];
		end
		if (en[6]) begin
			b_s6  <= b_s5;
			c_s6  <= c_s5;
			de_s6 <= p6[38:32];
		end
		if (en[7]) begin
			b_s7  <= b_s6;
			c_s7  <= c_s6;
			de_s7 <= de_s6;
			rd_s7 <= d7[11:0];
		end
		if (en[8]) begin
			b_s8 <= b_s7;
			c_s8 <= c_s7;
			d_s8 <= de_s7 + 7'(rd_s7 >= 12'(Days4y));
		end
		if (en[9]) begin
			e_s9  <= e9[8:0];
			yb_s9 <= y9[11:0];
		end
		if (en[10]) begin
			e_s10  <= e_s9;
			yb_s10 <= yb_s9;
			nm_s10 <= 11'(e_s9) * 11'(MdMul) + 11'(MdAdd);
		end
		if (en[11]) begin
			e_s11  <= e_s10;
			yb_s11 <= yb_s10;
			nm_s11 <= nm_s10;
			me_s11 <= p11[19:16];
		end
		if (en[12]) begin
			e_s12  <= e_s11;
			yb_s12 <= yb_s11;
			me_s12 <= me_s11;
			rm_s12 <= d12[8:0];
		end
		if (en[13]) begin
			e_s13  <= e_s12;
			yb_s13 <= yb_s12;
			m_s13  <= me_s12 + 4'(rm_s12 >= 9'(MdDiv));
		end
		if (en[14]) begin
			year_s14  <= yb_s13 + 12'(wrap14);
			month_s14 <= wrap14 ? m_s13 - 4'(WrapMonth - 1) : m_s13 + 4'(3);
			dom_s14   <= t14[4:0];
		end
	end

	assign year         = year_s14;
	assign month        = month_s14;
	assign day_of_month = dom_s14;
	assign clock_time   = tod_s[Stages];

endmodule

### hdl/unix_seconds_to_calendar_date.sv
// Top level: Unix seconds in, Gregorian date and time of day out.
//
//   Channel  Handshake           Payload
//   -------  ------------------  ------------------------------------------------------
//   input    in_valid, in_stall  unix_seconds[31:0]
//   output   out_valid, out_stall year[11:0], month[3:0], day_of_month[4:0],
//                                hour[4:0], minute[5:0], second[5:0]
//
// The pipeline is 23 register stages deep: 3 stages split off the day count, 6 stages
// derive hour, minute and second, and 14 stages run the calendar chain. A result sits
// in the last stage on the ports and transfers at an edge where out_stall is low.
// A new item can be taken every cycle while out_stall is low: one item per clock.
// Reset (arst_n low) empties the pipeline at once; no result is pending afterwards.
// A stall on the output holds the last stage. The hold passes back through full stages
// within the same cycle, so empty stages still fill, and the input stalls only when
// every stage holds an item and the output is stalled.
module unix_seconds_to_calendar_date (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [uscd_pkg::SecsW-1:0]  unix_seconds,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [uscd_pkg::YearW-1:0]  year,
	output logic [uscd_pkg::MonW-1:0]   month,
	output logic [uscd_pkg::DomW-1:0]   day_of_month,
	output logic [uscd_pkg::HourW-1:0]  hour,
	output logic [uscd_pkg::MinW-1:0]   minute,
	output logic [uscd_pkg::SecW-1:0]   second
);
	import uscd_pkg::*;

	// Handshake between the three sections: each section's ready is its first stage's
	// load enable, which is high when that stage is empty or will hand its item on.
	logic             split_ready;
	logic             split_valid;
	logic             time_ready;
	logic             time_valid;
	logic             date_ready;
	logic [DaysW-1:0] split_days;
	logic [SodW-1:0]  split_sod;
	logic [DaysW-1:0] time_days;
	tod_t             time_tod;
	tod_t             date_tod;

	// The input side stalls only when the first stage is full and cannot move on.
	assign in_stall = !split_ready;

	// Day count and seconds of the day, from an exact division by 86400.
	uscd_split u_split (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (split_ready),
		.unix_seconds (unix_seconds),
		.out_valid    (split_valid),
		.out_ready    (time_ready),
		.days         (split_days),
		.sod          (split_sod)
	);

	// Hour, minute and second; the day count rides along unchanged.
	uscd_time u_time (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (split_valid),
		.in_ready   (time_ready),
		.days       (split_days),
		.sod        (split_sod),
		.out_valid  (time_valid),
		.out_ready  (date_ready),
		.epoch_days (time_days),
		.tod        (time_tod)
	);

	// Calendar chain. Its last stage is the output register seen on the ports.
	uscd_date u_date (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (time_valid),
		.in_ready     (date_ready),
		.epoch_days   (time_days),
		.tod          (time_tod),
		.out_valid    (out_valid),
		.out_ready    (!out_stall),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.clock_time   (date_tod)
	);

	assign hour   = date_tod.hour;
	assign minute = date_tod.minute;
	assign second = date_tod.second;

endmodule

### tb/tb.sv
// Self-checking testbench for the Unix-seconds-to-calendar-date pipeline.
`timescale 1ns / 1ps

module tb;

	import uscd_pkg::*;

	// One decoded timestamp, at the widths of the output ports.
	typedef struct {
		logic [YearW-1:0] year;
		logic [MonW-1:0]  month;
		logic [DomW-1:0]  day_of_month;
		logic [HourW-1:0] hour;
		logic [MinW-1:0]  minute;
		logic [SecW-1:0]  second;
	} civil_time_t;

	localparam int RandomStamps = 1950;
	// Cycles without any transfer on either channel before the run is called hung.
	localparam int HangLimit = 5000;
	// The pipeline is 23 stages deep; the closing pause is sized from that depth.
	localparam int DrainCycles = 46;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [SecsW-1:0]    unix_seconds;
	logic                out_valid;
	logic                out_stall;
	logic [YearW-1:0]    year;
	logic [MonW-1:0]     month;
	logic [DomW-1:0]     day_of_month;
	logic [HourW-1:0]    hour;
	logic [MinW-1:0]     minute;
	logic [SecW-1:0]     second;

	// Timestamps not yet taken by the block, and decoded dates still to come out of it.
	logic [SecsW-1:0]    stamps_to_send[$];
	civil_time_t         dates_due[$];

	int                  stamps_total;
	int                  stamps_taken;
	int                  fail_count;
	int                  quiet_cycles;

	unix_seconds_to_calendar_date u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.unix_seconds (unix_seconds),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.hour         (hour),
		.minute       (minute),
		.second       (second)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Splits a timestamp into whole days and seconds of the day, then runs the
	// Calendar FAQ integer conversion on the Julian day number. All of it is exact
	// integer arithmetic, carried in 64 bits so that nothing can wrap.
	function automatic civil_time_t civil_from_unix(input logic [SecsW-1:0] stamp);
		civil_time_t ct;
		bit [63:0]   whole_days;
		bit [63:0]   secs_of_day;
		bit [63:0]   secs_of_hour;
		bit [63:0]   jd_shifted;
		bit [63:0]   era;
		bit [63:0]   day_of_era;
		bit [63:0]   quad;
		bit [63:0]   day_of_quad;
		bit [63:0]   march_month;
		bit [63:0]   year_wrap;
		whole_days   = 64'(stamp) / 64'd86400;
		secs_of_day  = 64'(stamp) % 64'd86400;
		ct.hour      = HourW'(secs_of_day / 64'd3600);
		secs_of_hour = secs_of_day % 64'd3600;
		ct.minute    = MinW'(secs_of_hour / 64'd60);
		ct.second    = SecW'(secs_of_hour % 64'd60);

		jd_shifted   = whole_days + 64'd2440588 + 64'd32044;
		era          = (64'd4 * jd_shifted + 64'd3) / 64'd146097;
		day_of_era   = jd_shifted - (64'd146097 * era) / 64'd4;
		quad         = (64'd4 * day_of_era + 64'd3) / 64'd1461;
		day_of_quad  = day_of_era - (64'd1461 * quad) / 64'd4;
		// Months are counted from March, so January and February wrap into the next year.
		march_month  = (64'd5 * day_of_quad + 64'd2) / 64'd153;
		year_wrap    = march_month / 64'd10;

		ct.day_of_month = DomW'(day_of_quad - (64'd153 * march_month + 64'd2) / 64'd5 + 64'd1);
		ct.month        = MonW'(march_month + 64'd3 - 64'd12 * year_wrap);
		ct.year         = YearW'(era * 64'd100 + quad + year_wrap - 64'd4800);
		return ct;
	endfunction

	// Idle rates in percent. The first third of the run has a lazy receiver, the
	// second a lazy sender, and the last third runs flat out on both sides.
	function automatic int sender_idle_pct(input int taken);
		if (taken < stamps_total / 3) begin
			return 30;
		end else if (taken < (2 * stamps_total) / 3) begin
			return 68;
		end
		return 0;
	endfunction

	function automatic int receiver_stall_pct(input int taken);
		if (taken < stamps_total / 3) begin
			return 68;
		end else if (taken < (2 * stamps_total) / 3) begin
			return 30;
		end
		return 0;
	endfunction

	// Driver. A transfer happens at an edge where in_valid is high and in_stall is
	// low; that timestamp is then decoded and its date queued. While the block
	// stalls, the payload is held. Otherwise the next timestamp goes out, unless the
	// sender chooses to idle this cycle. Each output gets a single assignment per edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				dates_due.push_back(civil_from_unix(unix_seconds));
				void'(stamps_to_send.pop_front());
				stamps_taken++;
			end
			if (!(in_valid && in_stall)) begin
				if (stamps_to_send.size() != 0 &&
				    $urandom_range(99) >= sender_idle_pct(stamps_taken)) begin
					in_valid     <= 1'b1;
					unix_seconds <= stamps_to_send[0];
				end else begin
					in_valid     <= 1'b0;
					unix_seconds <= $urandom;
				end
			end
		end
	end

	// The receiver stalls at random; the rate follows the phase of the run.
	always @(posedge clk) begin
		if (arst_n) begin
			out_stall <= ($urandom_range(99) < receiver_stall_pct(stamps_taken));
		end
	end

	// Monitor. Every output transfer is compared field by field with the oldest date
	// still expected. A transfer with nothing expected is a failure in its own right.
	always @(posedge clk) begin
		civil_time_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (dates_due.size() == 0) begin
				$error("unexpected output transfer: %0d-%0d-%0d %0d:%0d:%0d",
				       year, month, day_of_month, hour, minute, second);
				fail_count++;
			end else begin
				want = dates_due.pop_front();
				if (year !== want.year) begin
					$error("year: expected %0d, actual %0d", want.year, year);
					fail_count++;
				end
				if (month !== want.month) begin
					$error("month: expected %0d, actual %0d", want.month, month);
					fail_count++;
				end
				if (day_of_month !== want.day_of_month) begin
					$error("day_of_month: expected %0d, actual %0d",
					       want.day_of_month, day_of_month);
					fail_count++;
				end
				if (hour !== want.hour) begin
					$error("hour: expected %0d, actual %0d", want.hour, hour);
					fail_count++;
				end
				if (minute !== want.minute) begin
					$error("minute: expected %0d, actual %0d", want.minute, minute);
					fail_count++;
				end
				if (second !== want.second) begin
					$error("second: expected %0d, actual %0d", want.second, second);
					fail_count++;
				end
			end
		end
	end

	// Watchdog. Any transfer on either side resets the count of quiet cycles; a
	// long stretch without one means the block has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= HangLimit) begin
				$display("RESULT: ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		bit [63:0] near_midnight;
		int        day_index;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		out_stall    = 1'b0;
		unix_seconds = '0;
		fail_count   = 0;
		stamps_taken = 0;
		quiet_cycles = 0;

		// Directed timestamps: both ends of the input range, the edges of the time of
		// day, alternating bit patterns, the sign-bit boundary, year ends, the leap day
		// of a leap century and of an ordinary leap year, and the skipped leap day of
		// the year 2100, which is not a leap year.
		stamps_to_send.push_back(32'd0);
		stamps_to_send.push_back(32'hFFFF_FFFF);
		stamps_to_send.push_back(32'd1);
		stamps_to_send.push_back(32'd59);
		stamps_to_send.push_back(32'd60);
		stamps_to_send.push_back(32'd3599);
		stamps_to_send.push_back(32'd3600);
		stamps_to_send.push_back(32'd86399);
		stamps_to_send.push_back(32'd86400);
		stamps_to_send.push_back(32'h7FFF_FFFF);
		stamps_to_send.push_back(32'h8000_0000);
		stamps_to_send.push_back(32'hAAAA_AAAA);
		stamps_to_send.push_back(32'h5555_5555);
		stamps_to_send.push_back(32'd68169600);     // 1972-02-29
		stamps_to_send.push_back(32'd946684799);    // last second of 1999
		stamps_to_send.push_back(32'd946684800);    // first second of 2000
		stamps_to_send.push_back(32'd951782400);    // 2000-02-29
		stamps_to_send.push_back(32'd951868800);    // 2000-03-01
		stamps_to_send.push_back(32'd4107542399);   // 2100-02-28 23:59:59
		stamps_to_send.push_back(32'd4107542400);   // 2100-03-01 00:00:00
		stamps_to_send.push_back(32'd4233686400);   // 2104-02-29

		// Random timestamps: most are uniform over the whole range, so every input bit
		// toggles; the rest lie within two seconds of midnight, where day, month and year roll.
		repeat (RandomStamps) begin
			if ($urandom_range(99) < 60) begin
				stamps_to_send.push_back($urandom);
			end else begin
				day_index     = $urandom_range(49710);
				near_midnight = 64'(day_index) * 64'd86400;
				case ($urandom_range(3))
					0:       near_midnight = near_midnight;
					1:       near_midnight = near_midnight + 64'd1;
					2:       near_midnight = near_midnight + 64'd86399;
					default: near_midnight = near_midnight + 64'd86398;
				endcase
				if (near_midnight > 64'hFFFF_FFFF) begin
					near_midnight = 64'hFFFF_FFFF;
				end
				stamps_to_send.push_back(near_midnight[31:0]);
			end
		end
		stamps_total = stamps_to_send.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every timestamp has been taken and every date has come back,
		// then give the pipeline time to show any stray extra transfer.
		while (stamps_to_send.size() != 0 || dates_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);

		if (dates_due.size() != 0) begin
			$error("%0d dates never came out", dates_due.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
